/* rtl/core/snc_pkg.sv */
// shared constants and types of the sliding normalized correlator
package snc_pkg;

    localparam int DEF_MAX_TAPS    = 1024;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int SYM_LEN_BITS    = 11;
    localparam int SYM_LEN_MIN     = 2;
    localparam int TAP_IDX_BITS    = 10;
    localparam int CORR_BITS       = 32;
    localparam int SQRT_FRAC       = 16;
    localparam int SCALE_BASE      = 25;

    localparam logic CMD_TAP    = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef struct packed {
        logic                 zero;
        logic [CORR_BITS-1:0] re;
        logic [CORR_BITS-1:0] im;
    } snc_corr_t;

endpackage

/* rtl/core/sliding_normalized_correlator.sv */
// top level of the sliding normalized correlator
// Each sample request (cmd = 1) shifts into a circular window held in a
// single-port-write, registered-read memory, updates the running complex sum
// and energy by a read-modify-write of the oldest entry, then walks the window
// against the reference taps with one complex multiply-accumulate per cycle,
// and finally runs the bit-serial normalization unit (n * energy by shift-add,
// minus the squared sum, divide by n, square root, two parallel restoring
// quotients, saturation). A sample passes through two update states, the tap
// issues and the drain of the product pipeline, then the normalization unit
// (shorter when the spread is zero), then a hand-off state that waits until
// the result register is free, and returns to idle before the next request;
// the sample rate is set by the tap walk (one memory read a cycle) and the
// serial divider/root.
// A tap request (cmd = 0) is written in the cycle it is taken and produces no
// result. After reset and after every symbol_length write the window memory is
// swept to zero, during which no request is taken.
module sliding_normalized_correlator #(
    parameter int MAX_TAPS    = snc_pkg::DEF_MAX_TAPS,
    parameter int SAMPLE_BITS = snc_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [snc_pkg::SYM_LEN_BITS-1:0]    cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                cmd,
    input  logic [snc_pkg::TAP_IDX_BITS-1:0]    tap_index,
    input  logic signed [SAMPLE_BITS-1:0]       value_re,
    input  logic signed [SAMPLE_BITS-1:0]       value_im,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [snc_pkg::CORR_BITS-1:0] corr_re,
    output logic signed [snc_pkg::CORR_BITS-1:0] corr_im,
    output logic signed [SAMPLE_BITS-1:0]       oldest_re,
    output logic signed [SAMPLE_BITS-1:0]       oldest_im,
    output logic                                zero_spread
);
    import snc_pkg::*;

    localparam int B    = SAMPLE_BITS;
    localparam int AW   = $clog2(MAX_TAPS);
    localparam int NLW  = $clog2(MAX_TAPS + 1);
    localparam int SUMW = B + NLW;
    localparam int EW   = 2 * B + NLW;
    localparam int CACW = 2 * B + NLW + 1;
    localparam int IW   = (AW > TAP_IDX_BITS) ? AW : TAP_IDX_BITS;

    // control states
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_OLD   = 3'd2;
    localparam logic [2:0] ST_EN    = 3'd3;
    localparam logic [2:0] ST_MAC   = 3'd4;
    localparam logic [2:0] ST_NORM  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]            state_reg;
    logic [2:0]            state_next;
    logic [NLW-1:0]        n_reg;
    logic [AW-1:0]         wp_reg;
    logic [AW-1:0]         p_reg;
    logic [AW-1:0]         k_reg;
    logic [AW-1:0]         clr_addr_reg;
    logic [NLW-1:0]        iss_cnt_reg;
    logic signed [B-1:0]   new_re_reg;
    logic signed [B-1:0]   new_im_reg;
    logic signed [SUMW-1:0] sum_re_reg;
    logic signed [SUMW-1:0] sum_im_reg;
    logic [EW-1:0]         energy_reg;
    logic [2*B-1:0]        eo_reg;
    logic [2*B-1:0]        en_reg;
    logic                  v1_reg;
    logic                  v2_reg;
    logic                  first1_reg;
    logic signed [2*B-1:0] pr1_reg;
    logic signed [2*B-1:0] pr2_reg;
    logic signed [2*B-1:0] pr3_reg;
    logic signed [2*B-1:0] pr4_reg;
    logic signed [CACW-1:0] acc_re_reg;
    logic signed [CACW-1:0] acc_im_reg;
    logic signed [B-1:0]   oldest_re_reg;
    logic signed [B-1:0]   oldest_im_reg;
    logic                  out_valid_reg;
    logic signed [CORR_BITS-1:0] corr_re_reg;
    logic signed [CORR_BITS-1:0] corr_im_reg;
    logic signed [B-1:0]   out_old_re_reg;
    logic signed [B-1:0]   out_old_im_reg;
    logic                  zero_reg;

    // window memory {re, im}, and tap memory {re, im}
    logic [2*B-1:0] win_mem [MAX_TAPS];
    logic [2*B-1:0] tap_mem [MAX_TAPS];
    logic [2*B-1:0] win_q;
    logic [2*B-1:0] tap_q;
    logic           win_we;
    logic [AW-1:0]  win_waddr;
    logic [2*B-1:0] win_wdata;
    logic [AW-1:0]  win_raddr;
    logic           tap_we;
    logic [IW-1:0]  tap_ext;

    logic                  in_accept;
    logic [NLW-1:0]        n_cfg;
    logic [AW-1:0]         wp_inc;
    logic                  mac_issue;
    logic                  mac_done;
    logic                  norm_done;
    snc_corr_t             norm_res;
    logic                  out_free;
    logic                  out_load;
    logic signed [B-1:0]   o_re;
    logic signed [B-1:0]   o_im;
    logic signed [B-1:0]   w_re;
    logic signed [B-1:0]   w_im;
    logic signed [B-1:0]   t_re;
    logic signed [B-1:0]   t_im;
    logic signed [2*B-1:0] osq_re;
    logic signed [2*B-1:0] osq_im;
    logic signed [2*B-1:0] nsq_re;
    logic signed [2*B-1:0] nsq_im;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;

    // length write, clamped to the legal range
    always_comb
    begin
        if (int'(cfg_data) < SYM_LEN_MIN)
        begin
            n_cfg = NLW'(SYM_LEN_MIN);
        end
        else if (int'(cfg_data) > MAX_TAPS)
        begin
            n_cfg = NLW'(MAX_TAPS);
        end
        else
        begin
            n_cfg = NLW'(cfg_data);
        end
    end

    // oldest slot moves one place, wrapping at n
    assign wp_inc = (NLW'(p_reg) == n_reg - 1'b1) ? '0 : p_reg + 1'b1;

    assign mac_issue = (state_reg == ST_MAC) && (iss_cnt_reg < n_reg);
    assign mac_done  = (state_reg == ST_MAC) && (iss_cnt_reg == n_reg) && !v1_reg && !v2_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = (state_reg == ST_OUT) && out_free;

    // window entry split into parts
    assign o_re = win_q[2*B-1:B];
    assign o_im = win_q[B-1:0];
    assign w_re = win_q[2*B-1:B];
    assign w_im = win_q[B-1:0];
    assign t_re = tap_q[2*B-1:B];
    assign t_im = tap_q[B-1:0];

    assign osq_re = o_re * o_re;
    assign osq_im = o_im * o_im;
    assign nsq_re = new_re_reg * new_re_reg;
    assign nsq_im = new_im_reg * new_im_reg;

    // memory port selection
    assign win_we    = (state_reg == ST_CLEAR) || (state_reg == ST_OLD);
    assign win_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : p_reg;
    assign win_wdata = (state_reg == ST_CLEAR) ? '0 : {new_re_reg, new_im_reg};
    assign win_raddr = (state_reg == ST_IDLE) ? wp_reg : k_reg;

    assign tap_ext = IW'(tap_index);
    assign tap_we  = in_accept && (cmd == CMD_TAP) && (int'(tap_index) < MAX_TAPS);

    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            win_mem[win_waddr] <= win_wdata;
        end
        win_q <= win_mem[win_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tap_we)
        begin
            tap_mem[tap_ext[AW-1:0]] <= {value_re, value_im};
        end
        tap_q <= tap_mem[iss_cnt_reg[AW-1:0]];
    end

    // control sequence
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == AW'(MAX_TAPS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid && (cmd == CMD_SAMPLE))
                begin
                    state_next = ST_OLD;
                end
            end
            ST_OLD:
            begin
                state_next = ST_EN;
            end
            ST_EN:
            begin
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                if (mac_done)
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (norm_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        if (cfg_we)
        begin
            state_next = ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            n_reg         <= NLW'(MAX_TAPS);
            wp_reg        <= '0;
            clr_addr_reg  <= '0;
            iss_cnt_reg   <= '0;
            sum_re_reg    <= '0;
            sum_im_reg    <= '0;
            energy_reg    <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= mac_issue;
            v2_reg    <= v1_reg;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                // new length restarts the window from zero
                n_reg        <= n_cfg;
                wp_reg       <= '0;
                clr_addr_reg <= '0;
                sum_re_reg   <= '0;
                sum_im_reg   <= '0;
                energy_reg   <= '0;
            end
            else
            begin
                if (state_reg == ST_CLEAR)
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                end
                if (state_reg == ST_OLD)
                begin
                    sum_re_reg <= sum_re_reg - SUMW'(o_re) + SUMW'(new_re_reg);
                    sum_im_reg <= sum_im_reg - SUMW'(o_im) + SUMW'(new_im_reg);
                    wp_reg     <= wp_inc;
                end
                if (state_reg == ST_EN)
                begin
                    energy_reg <= energy_reg - EW'(eo_reg) + EW'(en_reg);
                end
            end
            if (state_reg == ST_EN)
            begin
                iss_cnt_reg <= '0;
            end
            else if (mac_issue)
            begin
                iss_cnt_reg <= iss_cnt_reg + 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept && (cmd == CMD_SAMPLE))
        begin
            new_re_reg <= value_re;
            new_im_reg <= value_im;
            p_reg      <= wp_reg;
        end
        if (state_reg == ST_OLD)
        begin
            // energy of the leaving and the entering sample
            eo_reg <= {1'b0, osq_re[2*B-2:0]} + {1'b0, osq_im[2*B-2:0]};
            en_reg <= {1'b0, nsq_re[2*B-2:0]} + {1'b0, nsq_im[2*B-2:0]};
            k_reg  <= wp_inc;
        end
        else if (mac_issue)
        begin
            k_reg <= (NLW'(k_reg) == n_reg - 1'b1) ? '0 : k_reg + 1'b1;
        end
        first1_reg <= mac_issue && (iss_cnt_reg == '0);
        if (v1_reg && first1_reg)
        begin
            oldest_re_reg <= w_re;
            oldest_im_reg <= w_im;
        end
        // conjugate products, registered ahead of the accumulator
        pr1_reg <= w_re * t_re;
        pr2_reg <= w_im * t_im;
        pr3_reg <= w_im * t_re;
        pr4_reg <= w_re * t_im;
        if (state_reg == ST_EN)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_re_reg <= acc_re_reg + CACW'(pr1_reg) + CACW'(pr2_reg);
            acc_im_reg <= acc_im_reg + CACW'(pr3_reg) - CACW'(pr4_reg);
        end
        if (out_load)
        begin
            corr_re_reg    <= norm_res.re;
            corr_im_reg    <= norm_res.im;
            zero_reg       <= norm_res.zero;
            out_old_re_reg <= oldest_re_reg;
            out_old_im_reg <= oldest_im_reg;
        end
    end

    snc_norm #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_norm (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mac_done),
        .n      (n_reg),
        .energy (energy_reg),
        .sum_re (sum_re_reg),
        .sum_im (sum_im_reg),
        .c_re   (acc_re_reg),
        .c_im   (acc_im_reg),
        .done   (norm_done),
        .result (norm_res)
    );

    assign out_valid   = out_valid_reg;
    assign corr_re     = corr_re_reg;
    assign corr_im     = corr_im_reg;
    assign oldest_re   = out_old_re_reg;
    assign oldest_im   = out_old_im_reg;
    assign zero_spread = zero_reg;

    // normalization finishes only while the sequencer waits for it
    a_norm_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        norm_done |-> state_reg == ST_NORM)
        else $error("normalization done outside its wait state");

    // the tap walk never issues past the window length
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MAC |-> iss_cnt_reg <= n_reg)
        else $error("tap walk ran past the window length");

    // the oldest slot stays inside the active window
    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> NLW'(wp_reg) < n_reg)
        else $error("window pointer outside the active length");

    // a result appears only from the hand-off state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised without a finished request");

endmodule

/* rtl/core/snc_norm.sv */
// normalization unit: spread, square root, quotient and saturation
module snc_norm #(
    parameter int MAX_TAPS    = snc_pkg::DEF_MAX_TAPS,
    parameter int SAMPLE_BITS = snc_pkg::DEF_SAMPLE_BITS,
    localparam int NLW  = $clog2(MAX_TAPS + 1),
    localparam int SUMW = SAMPLE_BITS + NLW,
    localparam int EW   = 2 * SAMPLE_BITS + NLW,
    localparam int CACW = 2 * SAMPLE_BITS + NLW + 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [NLW-1:0]         n,
    input  logic [EW-1:0]          energy,
    input  logic signed [SUMW-1:0] sum_re,
    input  logic signed [SUMW-1:0] sum_im,
    input  logic signed [CACW-1:0] c_re,
    input  logic signed [CACW-1:0] c_im,
    output logic                   done,
    output snc_pkg::snc_corr_t     result
);
    import snc_pkg::*;

    localparam int NEW  = EW + NLW;
    localparam int S2W  = 2 * SUMW;
    localparam int VW   = NEW;
    localparam int XW0  = VW + SQRT_FRAC;
    localparam int XW   = XW0 + (XW0 % 2);
    localparam int RW   = XW / 2;
    localparam int SH   = SCALE_BASE - SAMPLE_BITS;
    localparam int NUMW = CACW + SH;
    localparam int CNTW = $clog2(NUMW + VW + RW + NLW + 1);

    localparam logic [2:0] NS_IDLE = 3'd0;
    localparam logic [2:0] NS_MUL  = 3'd1;
    localparam logic [2:0] NS_SUB  = 3'd2;
    localparam logic [2:0] NS_DIV  = 3'd3;
    localparam logic [2:0] NS_SQRT = 3'd4;
    localparam logic [2:0] NS_QDIV = 3'd5;
    localparam logic [2:0] NS_DONE = 3'd6;

    localparam logic [NUMW-1:0] QMAX_POS = NUMW'(64'h7fff_ffff);
    localparam logic [NUMW-1:0] QMAX_NEG = NUMW'(64'h8000_0000);

    logic [2:0]            st_reg;
    logic [CNTW-1:0]       cnt_reg;
    logic [NLW-1:0]        n_sh_reg;
    logic [NLW-1:0]        n_hold_reg;
    logic [NEW-1:0]        e_sh_reg;
    logic [NEW-1:0]        acc_reg;
    logic signed [S2W-1:0] sq_re_reg;
    logic signed [S2W-1:0] sq_im_reg;
    logic [VW-1:0]         num_reg;
    logic [NLW-1:0]        drem_reg;
    logic [XW-1:0]         x_reg;
    logic [RW-1:0]         root_reg;
    logic [RW+1:0]         srem_reg;
    logic                  zero_reg;
    logic [NUMW-1:0]       qre_reg;
    logic [NUMW-1:0]       qim_reg;
    logic [RW-1:0]         rre_reg;
    logic [RW-1:0]         rim_reg;
    logic                  neg_re_reg;
    logic                  neg_im_reg;
    logic                  done_reg;
    snc_corr_t             res_reg;

    logic [CACW-1:0] abs_re;
    logic [CACW-1:0] abs_im;
    logic [VW-1:0]   s2;
    logic [NLW:0]    dsh;
    logic            dge;
    logic [NLW-1:0]  drem_next;
    logic [VW-1:0]   num_next;
    logic [RW+3:0]   ssh;
    logic [RW+3:0]   strial;
    logic            sge;
    logic [RW-1:0]   root_next;
    logic [RW:0]     qsh_re;
    logic [RW:0]     qsh_im;
    logic            qge_re;
    logic            qge_im;
    logic [CORR_BITS-1:0] sat_re;
    logic [CORR_BITS-1:0] sat_im;

    assign abs_re = c_re[CACW-1] ? CACW'(-c_re) : CACW'(c_re);
    assign abs_im = c_im[CACW-1] ? CACW'(-c_im) : CACW'(c_im);
    assign s2     = VW'(unsigned'(sq_re_reg)) + VW'(unsigned'(sq_im_reg));

    // restoring division of the spread by n
    assign dsh       = {drem_reg, num_reg[VW-1]};
    assign dge       = dsh >= {1'b0, n_hold_reg};
    assign drem_next = dge ? NLW'(dsh - {1'b0, n_hold_reg}) : dsh[NLW-1:0];
    assign num_next  = {num_reg[VW-2:0], dge};

    // square root, two radicand bits a step
    assign ssh       = {srem_reg, x_reg[XW-1:XW-2]};
    assign strial    = {2'b00, root_reg, 2'b01};
    assign sge       = ssh >= strial;
    assign root_next = {root_reg[RW-2:0], sge};

    // quotient of both components by the root
    assign qsh_re = {rre_reg, qre_reg[NUMW-1]};
    assign qsh_im = {rim_reg, qim_reg[NUMW-1]};
    assign qge_re = qsh_re >= {1'b0, root_reg};
    assign qge_im = qsh_im >= {1'b0, root_reg};

    always_comb
    begin
        if (neg_re_reg)
        begin
            sat_re = (qre_reg > QMAX_NEG) ? QMAX_NEG[CORR_BITS-1:0] : -qre_reg[CORR_BITS-1:0];
        end
        else
        begin
            sat_re = (qre_reg > QMAX_POS) ? QMAX_POS[CORR_BITS-1:0] : qre_reg[CORR_BITS-1:0];
        end
        if (neg_im_reg)
        begin
            sat_im = (qim_reg > QMAX_NEG) ? QMAX_NEG[CORR_BITS-1:0] : -qim_reg[CORR_BITS-1:0];
        end
        else
        begin
            sat_im = (qim_reg > QMAX_POS) ? QMAX_POS[CORR_BITS-1:0] : qim_reg[CORR_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= NS_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (st_reg)
                NS_IDLE:
                begin
                    if (start)
                    begin
                        st_reg  <= NS_MUL;
                        cnt_reg <= '0;
                    end
                end
                NS_MUL:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNTW'(NLW - 1))
                    begin
                        st_reg <= NS_SUB;
                    end
                end
                NS_SUB:
                begin
                    st_reg  <= NS_DIV;
                    cnt_reg <= '0;
                end
                NS_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNTW'(VW - 1))
                    begin
                        st_reg  <= NS_SQRT;
                        cnt_reg <= '0;
                    end
                end
                NS_SQRT:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNTW'(RW - 1))
                    begin
                        st_reg  <= zero_reg ? NS_DONE : NS_QDIV;
                        cnt_reg <= '0;
                    end
                end
                NS_QDIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNTW'(NUMW - 1))
                    begin
                        st_reg <= NS_DONE;
                    end
                end
                NS_DONE:
                begin
                    st_reg   <= NS_IDLE;
                    done_reg <= 1'b1;
                end
                default:
                begin
                    st_reg <= NS_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            NS_IDLE:
            begin
                if (start)
                begin
                    n_sh_reg   <= n;
                    n_hold_reg <= n;
                    e_sh_reg   <= NEW'(energy);
                    acc_reg    <= '0;
                    sq_re_reg  <= sum_re * sum_re;
                    sq_im_reg  <= sum_im * sum_im;
                    neg_re_reg <= c_re[CACW-1];
                    neg_im_reg <= c_im[CACW-1];
                    qre_reg    <= {abs_re, {SH{1'b0}}};
                    qim_reg    <= {abs_im, {SH{1'b0}}};
                end
            end
            NS_MUL:
            begin
                if (n_sh_reg[0])
                begin
                    acc_reg <= acc_reg + e_sh_reg;
                end
                e_sh_reg <= {e_sh_reg[NEW-2:0], 1'b0};
                n_sh_reg <= n_sh_reg >> 1;
            end
            NS_SUB:
            begin
                num_reg  <= (acc_reg >= s2) ? acc_reg - s2 : '0;
                drem_reg <= '0;
            end
            NS_DIV:
            begin
                num_reg  <= num_next;
                drem_reg <= drem_next;
                if (cnt_reg == CNTW'(VW - 1))
                begin
                    x_reg    <= XW'({num_next, {SQRT_FRAC{1'b0}}});
                    zero_reg <= (num_next == '0);
                    root_reg <= '0;
                    srem_reg <= '0;
                end
            end
            NS_SQRT:
            begin
                x_reg    <= {x_reg[XW-3:0], 2'b00};
                root_reg <= root_next;
                srem_reg <= sge ? (RW+2)'(ssh - strial) : ssh[RW+1:0];
                rre_reg  <= '0;
                rim_reg  <= '0;
            end
            NS_QDIV:
            begin
                rre_reg <= qge_re ? RW'(qsh_re - {1'b0, root_reg}) : qsh_re[RW-1:0];
                rim_reg <= qge_im ? RW'(qsh_im - {1'b0, root_reg}) : qsh_im[RW-1:0];
                qre_reg <= {qre_reg[NUMW-2:0], qge_re};
                qim_reg <= {qim_reg[NUMW-2:0], qge_im};
            end
            NS_DONE:
            begin
                res_reg.zero <= zero_reg;
                res_reg.re   <= zero_reg ? '0 : sat_re;
                res_reg.im   <= zero_reg ? '0 : sat_im;
            end
            default:
            begin
            end
        endcase
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
